@@ rtl/pdpi_ds_pkg.sv @@
// Package for the pointer DPI mode and drag-scroll controller.
// Holds the item structs, request codes and the mode constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdpi_ds_pkg;

   // Request codes carried in the req_type field.
   typedef enum logic [3:0] {
      REQ_MOTION      = 4'd0,
      REQ_DFLT_FWD    = 4'd1,
      REQ_DFLT_REV    = 4'd2,
      REQ_SNIPE_FWD   = 4'd3,
      REQ_SNIPE_REV   = 4'd4,
      REQ_DRAG_FWD    = 4'd5,
      REQ_DRAG_REV    = 4'd6,
      REQ_SNIPE_HOLD  = 4'd7,
      REQ_SNIPE_TOG   = 4'd8,
      REQ_DRAG_HOLD   = 4'd9,
      REQ_DRAG_TOG    = 4'd10,
      REQ_LOAD        = 4'd11,
      REQ_FACTORY     = 4'd12
   } req_code_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_REVERSE_X = 2'd1;
   localparam logic [1:0] CSR_REVERSE_Y = 2'd2;

   localparam int CsrDataWidth = 8;
   localparam logic [7:0] THRESHOLD_RESET = 8'd6;

   // Drag-scroll DPI limits and step.
   localparam logic [9:0] DRAG_STEP = 10'd100;
   localparam logic [9:0] DRAG_MAX  = 10'd500;
   localparam logic [8:0] DRAG_MIN  = 9'd100;

   // CPI bases and steps.
   localparam logic [11:0] DFLT_CPI_BASE  = 12'd400;
   localparam logic [11:0] DFLT_CPI_STEP  = 12'd200;
   localparam logic [11:0] SNIPE_CPI_BASE = 12'd200;
   localparam logic [11:0] SNIPE_CPI_STEP = 12'd100;

   typedef struct packed {
      logic [3:0]         req_type;
      logic               key_pressed;
      logic               shift_held;
      logic signed [7:0]  motion_x;
      logic signed [7:0]  motion_y;
      logic signed [7:0]  wheel_h_in;
      logic signed [7:0]  wheel_v_in;
      logic [16:0]        saved_word;
   } req_item_type;

   typedef struct packed {
      logic signed [7:0]  out_x;
      logic signed [7:0]  out_y;
      logic signed [7:0]  wheel_h_out;
      logic signed [7:0]  wheel_v_out;
      logic [11:0]        sensor_cpi;
      logic               save_request;
      logic [16:0]        settings_word;
      logic               sniping_on;
      logic               dragscroll_on;
   } rsp_item_type;

   // One axis of the scroll accumulator update.
   typedef struct packed {
      logic               hit;
      logic signed [7:0]  step;
      logic signed [9:0]  acc;
   } scroll_result_type;

endpackage

`default_nettype wire

@@ rtl/pointer_dpi_mode_and_drag_scroll.sv @@
// Top level of the pointer DPI mode and drag-scroll controller.
// Depends on pdpi_ds_pkg for item structs, request codes and constants.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one item per cycle while the result side does not stall
// and returns exactly one result item for each, via the result register.
// An accepted item lands in an input register; the next cycle one pass of
// shallow logic reads it together with the mode state (DPI indexes, drag
// DPI, sniping and drag-scroll flags, two 10-bit scroll accumulators),
// updates that state and loads the result register. Back-to-back items see
// each other's state updates because the state is written in the same edge
// that captures the result. A stall on the result side holds the result
// register and, once the input register is full too, raises req_stall.
// Motion items pass through unless drag-scroll is on; then the motion is
// zeroed and added into the accumulators, and a one-step wheel value is sent
// when an accumulator's magnitude exceeds the threshold register. Write the
// configuration registers only while the block is idle.
module pointer_dpi_mode_and_drag_scroll (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire pdpi_ds_pkg::req_item_type     req_item,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      pdpi_ds_pkg::rsp_item_type     rsp_item,
   input  wire logic                          csr_write_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [pdpi_ds_pkg::CsrDataWidth-1:0] csr_write_data
);
   import pdpi_ds_pkg::*;

   // Accumulate one axis; saturate, then fire and clear past the threshold.
   function automatic scroll_result_type scroll_axis(
      input logic signed [9:0] acc,
      input logic signed [7:0] motion,
      input logic              rev,
      input logic [7:0]        thr
   );
      logic signed [10:0] sum;
      logic signed [9:0]  sat;
      logic [9:0]         mag;
      scroll_result_type  r;
      if (rev) begin
         sum = $signed({acc[9], acc} - {{3{motion[7]}}, motion});
      end else begin
         sum = $signed({acc[9], acc} + {{3{motion[7]}}, motion});
      end
      if (sum > 11'sd511) begin
         sat = 10'sd511;
      end else if (sum < -11'sd512) begin
         sat = -10'sd512;
      end else begin
         sat = sum[9:0];
      end
      mag = sat[9] ? 10'(-sat) : sat;
      r.hit  = (mag > {2'b00, thr});
      r.step = (sat > 10'sd0) ? 8'sd1 : -8'sd1;
      r.acc  = r.hit ? 10'sd0 : sat;
      return r;
   endfunction

   // Configuration registers.
   logic [7:0] threshold_ff;
   logic       reverse_x_ff;
   logic       reverse_y_ff;

   // Input stage.
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         s1_take;
   logic         req_accept;

   // Mode state and its next values.
   logic [8:0]        drag_dpi_ff,   drag_dpi_in;
   logic [3:0]        dflt_idx_ff,   dflt_idx_in;
   logic [1:0]        snipe_idx_ff,  snipe_idx_in;
   logic              drag_flag_ff,  drag_flag_in;
   logic              snipe_flag_ff, snipe_flag_in;
   logic signed [9:0] acc_x_ff,      acc_x_in;
   logic signed [9:0] acc_y_ff,      acc_y_in;

   // Result register.
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic              fwd;
   logic [9:0]        drag_up;
   scroll_result_type sx;
   scroll_result_type sy;

   // Advance the input stage when the result register is free or being taken.
   assign s1_take    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_take;
   assign req_accept = req_valid & ~req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign drag_up = {1'b0, drag_dpi_ff} + DRAG_STEP;
   assign sx = scroll_axis(acc_x_ff, s1_item_ff.motion_x, reverse_x_ff, threshold_ff);
   assign sy = scroll_axis(acc_y_ff, s1_item_ff.motion_y, reverse_y_ff, threshold_ff);

   always_comb begin
      drag_dpi_in   = drag_dpi_ff;
      dflt_idx_in   = dflt_idx_ff;
      snipe_idx_in  = snipe_idx_ff;
      drag_flag_in  = drag_flag_ff;
      snipe_flag_in = snipe_flag_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      fwd           = 1'b0;
      rsp_item_in   = '0;

      case (s1_item_ff.req_type)
         REQ_MOTION: begin
            rsp_item_in.out_x       = s1_item_ff.motion_x;
            rsp_item_in.out_y       = s1_item_ff.motion_y;
            rsp_item_in.wheel_h_out = s1_item_ff.wheel_h_in;
            rsp_item_in.wheel_v_out = s1_item_ff.wheel_v_in;
            if (drag_flag_ff) begin
               // Drop the motion; feed it into the scroll accumulators.
               rsp_item_in.out_x = 8'sd0;
               rsp_item_in.out_y = 8'sd0;
               acc_x_in = sx.acc;
               acc_y_in = sy.acc;
               if (sx.hit) begin
                  rsp_item_in.wheel_h_out = sx.step;
               end
               if (sy.hit) begin
                  rsp_item_in.wheel_v_out = sy.step;
               end
            end
         end
         REQ_DFLT_FWD, REQ_DFLT_REV: begin
            if (s1_item_ff.key_pressed) begin
               fwd = (s1_item_ff.req_type == REQ_DFLT_FWD) ^ s1_item_ff.shift_held;
               dflt_idx_in = fwd ? dflt_idx_ff + 4'd1 : dflt_idx_ff - 4'd1;
               rsp_item_in.save_request = 1'b1;
            end
         end
         REQ_SNIPE_FWD, REQ_SNIPE_REV: begin
            if (s1_item_ff.key_pressed) begin
               fwd = (s1_item_ff.req_type == REQ_SNIPE_FWD) ^ s1_item_ff.shift_held;
               snipe_idx_in = fwd ? snipe_idx_ff + 2'd1 : snipe_idx_ff - 2'd1;
               rsp_item_in.save_request = 1'b1;
            end
         end
         REQ_DRAG_FWD: begin
            if (s1_item_ff.key_pressed) begin
               // Wrap back to the minimum past the top.
               drag_dpi_in = (drag_up > DRAG_MAX) ? DRAG_MIN : drag_up[8:0];
               rsp_item_in.save_request = 1'b1;
            end
         end
         REQ_DRAG_REV: begin
            if (s1_item_ff.key_pressed) begin
               // Below the minimum, wrap to the top.
               drag_dpi_in = (drag_dpi_ff < DRAG_MIN) ? DRAG_MAX[8:0]
                                                      : drag_dpi_ff - DRAG_MIN;
               rsp_item_in.save_request = 1'b1;
            end
         end
         REQ_SNIPE_HOLD: begin
            snipe_flag_in = s1_item_ff.key_pressed;
         end
         REQ_SNIPE_TOG: begin
            if (s1_item_ff.key_pressed) begin
               snipe_flag_in = ~snipe_flag_ff;
            end
         end
         REQ_DRAG_HOLD: begin
            drag_flag_in = s1_item_ff.key_pressed;
         end
         REQ_DRAG_TOG: begin
            if (s1_item_ff.key_pressed) begin
               drag_flag_in = ~drag_flag_ff;
            end
         end
         REQ_LOAD: begin
            drag_dpi_in   = s1_item_ff.saved_word[8:0];
            dflt_idx_in   = s1_item_ff.saved_word[12:9];
            snipe_idx_in  = s1_item_ff.saved_word[14:13];
            drag_flag_in  = 1'b0;
            snipe_flag_in = 1'b0;
         end
         REQ_FACTORY: begin
            drag_dpi_in   = '0;
            dflt_idx_in   = '0;
            snipe_idx_in  = '0;
            drag_flag_in  = 1'b0;
            snipe_flag_in = 1'b0;
            rsp_item_in.save_request = 1'b1;
         end
         default: begin
         end
      endcase

      // Select the CPI from the updated mode.
      if (drag_flag_in) begin
         rsp_item_in.sensor_cpi = {3'b000, drag_dpi_in};
      end else if (snipe_flag_in) begin
         rsp_item_in.sensor_cpi = SNIPE_CPI_BASE + 12'(snipe_idx_in) * SNIPE_CPI_STEP;
      end else begin
         rsp_item_in.sensor_cpi = DFLT_CPI_BASE + 12'(dflt_idx_in) * DFLT_CPI_STEP;
      end
      rsp_item_in.settings_word = {snipe_flag_in, drag_flag_in, snipe_idx_in,
                                   dflt_idx_in, drag_dpi_in};
      rsp_item_in.sniping_on    = snipe_flag_in;
      rsp_item_in.dragscroll_on = drag_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         reverse_x_ff  <= 1'b0;
         reverse_y_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         drag_dpi_ff   <= '0;
         dflt_idx_ff   <= '0;
         snipe_idx_ff  <= '0;
         drag_flag_ff  <= 1'b0;
         snipe_flag_ff <= 1'b0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_write_data[7:0];
               CSR_REVERSE_X: reverse_x_ff <= csr_write_data[0];
               CSR_REVERSE_Y: reverse_y_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end

         // Fill or drain the input stage.
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_take) begin
            s1_valid_ff <= 1'b0;
         end

         // Commit state and load the result together.
         if (s1_take) begin
            drag_dpi_ff   <= drag_dpi_in;
            dflt_idx_ff   <= dflt_idx_in;
            snipe_idx_ff  <= snipe_idx_in;
            drag_flag_ff  <= drag_flag_in;
            snipe_flag_ff <= snipe_flag_in;
            acc_x_ff      <= acc_x_in;
            acc_y_ff      <= acc_y_in;
            rsp_valid_ff  <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (s1_take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

`default_nettype wire
